/* design/pmq_pkg.sv */
// shared constants, codes and types of the priority message queue
`timescale 1ns / 1ps

package pmq_pkg;

    // storage geometry
    localparam int SLOT_COUNT = 8;
    localparam int MSG_WORDS  = 16;

    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int WIDX_W    = (MSG_WORDS > 1) ? $clog2(MSG_WORDS) : 1;
    localparam int WCNT_W    = $clog2(MSG_WORDS + 1);
    localparam int MEM_DEPTH = SLOT_COUNT * MSG_WORDS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
    localparam int LIMIT_CAP = MSG_WORDS * 8;

    // field widths
    localparam int PRIO_W      = 16;
    localparam int LEN_W       = 12;
    localparam int DATA_W      = 64;
    localparam int MLEN_W      = 8;
    localparam int QCOUNT_W    = 4;
    localparam int ORDER_W     = 32;
    localparam int MAXMSG_W    = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [PRIO_W-1:0] PRIO_MAX = 16'd32768;

    // request kinds
    localparam logic REQ_SEND = 1'b0;
    localparam logic REQ_RECV = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT   = 1'b1;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_TOO_LONG  = 3'd1,
        STS_FULL      = 3'd2,
        STS_EMPTY     = 3'd3,
        STS_TOO_SMALL = 3'd4,
        STS_BAD_PRIO  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_FETCH,
        S_EMIT
    } t_state;

endpackage

/* design/pmq_req_if.sv */
// request channel: send payload beats and receive requests
`timescale 1ns / 1ps

interface pmq_req_if;
    import pmq_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [PRIO_W-1:0] priority_req;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] payload_word;
    logic              final_word;

    modport source (
        output valid, req_type, priority_req, length, payload_word, final_word,
        input  ready
    );

    modport sink (
        input  valid, req_type, priority_req, length, payload_word, final_word,
        output ready
    );
endinterface

/* design/pmq_rsp_if.sv */
// response channel: status and received data beats
`timescale 1ns / 1ps

interface pmq_rsp_if;
    import pmq_pkg::*;

    logic                valid;
    logic                ready;
    t_status             status;
    logic [MLEN_W-1:0]   message_length;
    logic [PRIO_W-1:0]   message_priority;
    logic [DATA_W-1:0]   data_out;
    logic                last_out;
    logic [QCOUNT_W-1:0] queued_count;

    modport source (
        output valid, status, message_length, message_priority, data_out, last_out,
               queued_count,
        input  ready
    );

    modport sink (
        input  valid, status, message_length, message_priority, data_out, last_out,
               queued_count,
        output ready
    );
endinterface

/* design/priority_message_queue.sv */
// Fixed-slot priority message queue. A send is a run of request beats, one accepted per
// cycle while the block is idle and its output register is free; the first beat is checked
// (priority, length, room) and the final beat yields one status beat. A receive scans the
// slot table one slot per cycle, decides in S_DECIDE, then streams the message from the
// payload memory, each data beat passing a memory read (S_FETCH) and then the output
// register (S_EMIT); no new beat is taken until the receive is back in S_IDLE. Output
// back-pressure can hold S_DECIDE and S_EMIT. Configuration is written through the plain
// write port; the user must write it only while the block is idle, and the block itself
// does not enforce this.
`timescale 1ns / 1ps

module priority_message_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pmq_req_if.sink                        i_req,
    pmq_rsp_if.source                      o_rsp,
    input  logic                           i_cfg_we,
    input  logic [pmq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pmq_pkg::*;

    // configuration
    logic [MAXMSG_W-1:0] r_max_msgs;
    logic [MLEN_W-1:0]   r_size_limit;

    // slot table
    logic [SLOT_COUNT-1:0] r_valid;
    logic [ORDER_W-1:0]    r_order [SLOT_COUNT];
    logic [PRIO_W-1:0]     r_prio  [SLOT_COUNT];
    logic [MLEN_W-1:0]     r_len   [SLOT_COUNT];
    logic [ORDER_W-1:0]    r_next_order;
    logic [CNT_W-1:0]      r_count;

    // payload memory
    logic [DATA_W-1:0] payload_mem [MEM_DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // send in progress
    logic              r_snd_active;
    t_status           r_snd_err;
    logic [SLOT_W-1:0] r_snd_slot;
    logic [WCNT_W-1:0] r_snd_word;
    logic [MLEN_W-1:0] r_snd_len;
    logic [PRIO_W-1:0] r_snd_pri;

    // receive
    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_cap;
    logic [SLOT_W-1:0]  r_scan_idx;
    logic               r_found;
    logic [SLOT_W-1:0]  r_best;
    logic [PRIO_W-1:0]  r_best_pri;
    logic [ORDER_W-1:0] r_best_order;
    logic [MLEN_W-1:0]  r_best_len;
    logic [WIDX_W-1:0]  r_word_idx;
    logic [WIDX_W-1:0]  r_last_idx;

    // output register
    logic                r_out_valid;
    t_status             r_out_status;
    logic [MLEN_W-1:0]   r_out_len;
    logic [PRIO_W-1:0]   r_out_pri;
    logic [DATA_W-1:0]   r_out_data;
    logic                r_out_last;
    logic [QCOUNT_W-1:0] r_out_count;

    // derived limits
    logic [7:0]       eff_max;
    logic [LEN_W-1:0] eff_limit;

    // control strobes
    logic out_free, in_ready, acc_send, acc_recv;
    logic scan_take, decide_err, decide_take, mem_rd, emit_load;
    t_status decide_sts;

    // send checks
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
    t_status           first_err, snd_err_now;
    logic [SLOT_W-1:0] snd_slot_now;
    logic [WCNT_W-1:0] snd_word_now;
    logic              store_we, commit;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    // receive data shaping
    logic [9:0]        nwords;
    logic [LEN_W-1:0]  word_base;
    logic [DATA_W-1:0] masked_data;

    always_comb begin
        eff_max   = (8'(r_max_msgs) > 8'(SLOT_COUNT)) ? 8'(SLOT_COUNT) : 8'(r_max_msgs);
        eff_limit = (LEN_W'(r_size_limit) > LEN_W'(LIMIT_CAP)) ? LEN_W'(LIMIT_CAP)
                                                                : LEN_W'(r_size_limit);
    end

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(s);
            end
        end
    end

    always_comb begin
        priority if (i_req.priority_req > PRIO_MAX) begin
            first_err = STS_BAD_PRIO;
        end else if (i_req.length > eff_limit) begin
            first_err = STS_TOO_LONG;
        end else if (8'(r_count) >= eff_max || !free_found) begin
            first_err = STS_FULL;
        end else begin
            first_err = STS_OK;
        end
        snd_err_now  = r_snd_active ? r_snd_err  : first_err;
        snd_slot_now = r_snd_active ? r_snd_slot : free_slot;
        snd_word_now = r_snd_active ? r_snd_word : '0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc_recv) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_scan_idx == SLOT_W'(SLOT_COUNT - 1)) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (decide_take) n_state = S_FETCH;
                else if (out_free) n_state = S_IDLE;
            end
            S_FETCH: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = (r_word_idx == r_last_idx) ? S_IDLE : S_FETCH;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        out_free    = !r_out_valid || o_rsp.ready;
        in_ready    = 1'b0;
        scan_take   = 1'b0;
        decide_err  = 1'b0;
        decide_take = 1'b0;
        decide_sts  = STS_EMPTY;
        mem_rd      = 1'b0;
        emit_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_ready = out_free;
            end
            S_SCAN: begin
                scan_take = r_valid[r_scan_idx] &&
                            (!r_found || r_prio[r_scan_idx] > r_best_pri ||
                             (r_prio[r_scan_idx] == r_best_pri &&
                              r_order[r_scan_idx] < r_best_order));
            end
            S_DECIDE: begin
                if (!r_found) begin
                    decide_err = out_free;
                    decide_sts = STS_EMPTY;
                end else if (r_cap < eff_limit) begin
                    decide_err = out_free;
                    decide_sts = STS_TOO_SMALL;
                end else begin
                    decide_take = 1'b1;
                end
            end
            S_FETCH: begin
                mem_rd = 1'b1;
            end
            S_EMIT: begin
                emit_load = out_free;
            end
            default: ;
        endcase
        acc_send = i_req.valid && in_ready && (i_req.req_type == REQ_SEND);
        acc_recv = i_req.valid && in_ready && (i_req.req_type == REQ_RECV);
        store_we = acc_send && (snd_err_now == STS_OK) && (snd_word_now < WCNT_W'(MSG_WORDS));
        commit   = acc_send && i_req.final_word && (snd_err_now == STS_OK);
    end

    always_comb begin
        wr_addr = ADDR_W'(snd_slot_now) * ADDR_W'(MSG_WORDS)
                + ADDR_W'(snd_word_now[WIDX_W-1:0]);
        rd_addr = ADDR_W'(r_best) * ADDR_W'(MSG_WORDS) + ADDR_W'(r_word_idx);
        nwords  = (10'(r_best_len) + 10'd7) >> 3;
        if (nwords == 10'd0) nwords = 10'd1;
        if (nwords > 10'(MSG_WORDS)) nwords = 10'(MSG_WORDS);
        // bytes past the message length read as zero
        word_base = LEN_W'({r_word_idx, 3'b000});
        for (int b = 0; b < 8; b++) begin
            masked_data[b*8 +: 8] = (word_base + LEN_W'(b) < LEN_W'(r_best_len))
                                  ? r_rd_data[b*8 +: 8] : 8'h00;
        end
    end

    // payload memory: sends write while idle, receives read later, so no overlap
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            payload_mem[wr_addr] <= i_req.payload_word;
        end
        if (mem_rd) begin
            r_rd_data <= payload_mem[rd_addr];
        end
    end

    // slot fields and payload registers
    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_order[snd_slot_now] <= r_next_order;
            r_prio[snd_slot_now]  <= r_snd_active ? r_snd_pri : i_req.priority_req;
            r_len[snd_slot_now]   <= r_snd_active ? r_snd_len : i_req.length[MLEN_W-1:0];
        end
        if (acc_send && !r_snd_active) begin
            r_snd_slot <= free_slot;
            r_snd_len  <= i_req.length[MLEN_W-1:0];
            r_snd_pri  <= i_req.priority_req;
        end
        if (acc_recv) begin
            r_cap <= i_req.length;
        end
        if (scan_take) begin
            r_best       <= r_scan_idx;
            r_best_pri   <= r_prio[r_scan_idx];
            r_best_order <= r_order[r_scan_idx];
            r_best_len   <= r_len[r_scan_idx];
        end
        if (decide_take) begin
            r_word_idx <= '0;
            r_last_idx <= WIDX_W'(nwords - 10'd1);
        end else if (emit_load) begin
            r_word_idx <= r_word_idx + WIDX_W'(1);
        end
        if (acc_send && i_req.final_word) begin
            r_out_status <= snd_err_now;
            r_out_len    <= '0;
            r_out_pri    <= '0;
            r_out_data   <= '0;
            r_out_last   <= 1'b1;
            r_out_count  <= QCOUNT_W'(r_count + CNT_W'(commit));
        end else if (decide_err) begin
            r_out_status <= decide_sts;
            r_out_len    <= '0;
            r_out_pri    <= '0;
            r_out_data   <= '0;
            r_out_last   <= 1'b1;
            r_out_count  <= QCOUNT_W'(r_count);
        end else if (emit_load) begin
            r_out_status <= STS_OK;
            r_out_len    <= r_best_len;
            r_out_pri    <= r_best_pri;
            r_out_data   <= masked_data;
            r_out_last   <= (r_word_idx == r_last_idx);
            r_out_count  <= QCOUNT_W'(r_count);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_max_msgs   <= MAXMSG_W'(SLOT_COUNT);
            r_size_limit <= MLEN_W'(LIMIT_CAP);
            r_valid      <= '0;
            r_next_order <= '0;
            r_count      <= '0;
            r_snd_active <= 1'b0;
            r_snd_err    <= STS_OK;
            r_snd_word   <= '0;
            r_scan_idx   <= '0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAX_MESSAGES) r_max_msgs <= i_cfg_data[MAXMSG_W-1:0];
                if (i_cfg_idx == CFG_SIZE_LIMIT) r_size_limit <= i_cfg_data[MLEN_W-1:0];
            end
            if (acc_send) begin
                r_snd_active <= !i_req.final_word;
                r_snd_err    <= snd_err_now;
                r_snd_word   <= snd_word_now + WCNT_W'(store_we);
            end
            if (commit) begin
                r_valid[snd_slot_now] <= 1'b1;
                r_next_order          <= r_next_order + ORDER_W'(1);
                r_count               <= r_count + CNT_W'(1);
            end else if (decide_take) begin
                r_valid[r_best] <= 1'b0;
                r_count         <= r_count - CNT_W'(1);
            end
            if (acc_recv) begin
                r_scan_idx <= '0;
                r_found    <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_scan_idx <= r_scan_idx + SLOT_W'(1);
                if (scan_take) r_found <= 1'b1;
            end
            if (acc_send && i_req.final_word || decide_err || emit_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_req.ready            = in_ready;
    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.status           = r_out_status;
    assign o_rsp.message_length   = r_out_len;
    assign o_rsp.message_priority = r_out_pri;
    assign o_rsp.data_out         = r_out_data;
    assign o_rsp.last_out         = r_out_last;
    assign o_rsp.queued_count     = r_out_count;

endmodule
